// ===== design/urms_pkg.sv =====
// Shared types, register map and constants for the ultrasonic ranger motor stop block.
package urms_pkg;

  // Echo width counter default size.
  localparam int COUNT_WIDTH_DEF = 16;

  // Configuration port geometry.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Field widths.
  localparam int CNT16_W = 16;
  localparam int TWID_W  = 8;
  localparam int PCT_W   = 7;
  localparam int DIST_W  = 11;
  localparam int DUTY_W  = CNT16_W + PCT_W;
  localparam int SCALE_W = DUTY_W + 1;

  // Echo ticks per centimeter and the remainder counter that tracks them.
  localparam int ECHO_PER_CM = 58;
  localparam int REM_W       = $clog2(ECHO_PER_CM);
  localparam logic [REM_W-1:0]  REM_LAST = REM_W'(ECHO_PER_CM - 1);
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  // Percent scaling for the PWM duty.
  localparam logic [PCT_W-1:0]   SPEED_MAX = PCT_W'(100);
  localparam logic [SCALE_W-1:0] PCT_SCALE = SCALE_W'(100);

  // Register reset values.
  localparam logic [CNT16_W-1:0] TRIG_PERIOD_RST = 16'd65000;
  localparam logic [TWID_W-1:0]  TRIG_WIDTH_RST  = 8'd10;
  localparam logic [CNT16_W-1:0] PWM_PERIOD_RST  = 16'd5000;
  localparam logic [PCT_W-1:0]   SPEED_RST       = 7'd50;
  localparam logic [DIST_W-1:0]  STOP_BELOW_RST  = 11'd20;
  localparam logic [DIST_W-1:0]  START_FROM_RST  = 11'd10;
  localparam logic [CNT16_W-1:0] HOLD_TICKS_RST  = 16'd10000;

  // Register indexes (word address bits of paddr).
  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_TRIG_PERIOD = 3'd0;
  localparam reg_idx_t REG_TRIG_WIDTH  = 3'd1;
  localparam reg_idx_t REG_PWM_PERIOD  = 3'd2;
  localparam reg_idx_t REG_SPEED       = 3'd3;
  localparam reg_idx_t REG_STOP_BELOW  = 3'd4;
  localparam reg_idx_t REG_START_FROM  = 3'd5;
  localparam reg_idx_t REG_HOLD_TICKS  = 3'd6;

  // Configuration register set.
  typedef struct packed {
    logic [CNT16_W-1:0] trigger_period;
    logic [TWID_W-1:0]  trigger_width;
    logic [CNT16_W-1:0] pwm_period;
    logic [PCT_W-1:0]   speed_percent;
    logic [DIST_W-1:0]  stop_below_cm;
    logic [DIST_W-1:0]  start_from_cm;
    logic [CNT16_W-1:0] hold_ticks;
  } cfg_t;

  // One result of a tick.
  typedef struct packed {
    logic              trigger_out;
    logic              pwm_left;
    logic              pwm_right;
    logic              left_in1;
    logic              left_in2;
    logic              right_in1;
    logic              right_in2;
    logic [DIST_W-1:0] distance_cm;
    logic              distance_new;
    logic              motors_running;
  } result_t;

  // Stream payload widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

endpackage

// ===== design/ultrasonic_ranger_motor_stop.sv =====
// Top level of the ultrasonic ranger with motor stop: config port, core and output skid.
//
//   Port group  Direction  Content
//   in_*        slave      one request per 1 us tick, echo level sample
//   out_*       master     one request per tick with trigger, PWM, bridge and range levels
//   cfg_*       slave      APB-style register access, seven registers at 4*i
//
// The core updates its counters from the input request and the result is registered,
// so a new request is taken every cycle while out_tready holds.
// A two-entry output stage (output register plus skid) keeps in_tready registered;
// in_tready drops only when both entries are full.
// Reset (rst_n low, synchronous) restores register defaults and clears all counters.
module ultrasonic_ranger_motor_stop #(
  parameter int COUNT_WIDTH = urms_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: [0] echo_level, [7:1] zero
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [urms_pkg::IN_DATA_W-1:0]    in_tdata,
  // tdata: [0] trigger_out, [1] pwm_left, [2] pwm_right, [3] left_in1, [4] left_in2,
  //        [5] right_in1, [6] right_in2, [17:7] distance_cm, [18] distance_new,
  //        [19] motors_running, [23:20] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [urms_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [urms_pkg::ADDR_W-1:0]       cfg_paddr,
  input  logic [urms_pkg::DATA_W-1:0]       cfg_pwdata,
  output logic [urms_pkg::DATA_W-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import urms_pkg::*;

  cfg_t                  cfg;
  result_t               res;
  logic                  in_acc;
  logic                  out_take;
  logic [OUT_DATA_W-1:0] res_data;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_DATA_W-1:0] skid_data_r;
  logic                  out_valid_r;
  logic                  skid_valid_r;

  urms_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  urms_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_acc),
    .echo_level (in_tdata[0]),
    .cfg        (cfg),
    .res        (res)
  );

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;

  // Pack the result, first field in the lowest bit.
  assign res_data = {4'b0000, res.motors_running, res.distance_new, res.distance_cm,
                     res.right_in2, res.right_in1, res.left_in2, res.left_in1,
                     res.pwm_right, res.pwm_left, res.trigger_out};

  // Output register and skid entry control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output and skid payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_data_r <= res_data;
      end else begin
        skid_data_r <= res_data;
      end
    end else if (out_take && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/urms_regs.sv =====
// APB-style configuration register file for the ranger block.
module urms_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [urms_pkg::ADDR_W-1:0]   paddr,
  input  logic [urms_pkg::DATA_W-1:0]   pwdata,
  output logic [urms_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output urms_pkg::cfg_t                cfg
);
  import urms_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes, each masked to its width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trigger_period <= TRIG_PERIOD_RST;
      cfg_r.trigger_width  <= TRIG_WIDTH_RST;
      cfg_r.pwm_period     <= PWM_PERIOD_RST;
      cfg_r.speed_percent  <= SPEED_RST;
      cfg_r.stop_below_cm  <= STOP_BELOW_RST;
      cfg_r.start_from_cm  <= START_FROM_RST;
      cfg_r.hold_ticks     <= HOLD_TICKS_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_TRIG_PERIOD: cfg_r.trigger_period <= pwdata[CNT16_W-1:0];
        REG_TRIG_WIDTH:  cfg_r.trigger_width  <= pwdata[TWID_W-1:0];
        REG_PWM_PERIOD:  cfg_r.pwm_period     <= pwdata[CNT16_W-1:0];
        REG_SPEED:       cfg_r.speed_percent  <= pwdata[PCT_W-1:0];
        REG_STOP_BELOW:  cfg_r.stop_below_cm  <= pwdata[DIST_W-1:0];
        REG_START_FROM:  cfg_r.start_from_cm  <= pwdata[DIST_W-1:0];
        REG_HOLD_TICKS:  cfg_r.hold_ticks     <= pwdata[CNT16_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the selected register.
  always_comb begin
    unique case (idx)
      REG_TRIG_PERIOD: prdata = DATA_W'(cfg_r.trigger_period);
      REG_TRIG_WIDTH:  prdata = DATA_W'(cfg_r.trigger_width);
      REG_PWM_PERIOD:  prdata = DATA_W'(cfg_r.pwm_period);
      REG_SPEED:       prdata = DATA_W'(cfg_r.speed_percent);
      REG_STOP_BELOW:  prdata = DATA_W'(cfg_r.stop_below_cm);
      REG_START_FROM:  prdata = DATA_W'(cfg_r.start_from_cm);
      REG_HOLD_TICKS:  prdata = DATA_W'(cfg_r.hold_ticks);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== design/urms_core.sv =====
// Per-tick state update: echo timing, stop/start decision, trigger and PWM counters.
module urms_core #(
  parameter int COUNT_WIDTH = urms_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              echo_level,
  input  urms_pkg::cfg_t    cfg,
  output urms_pkg::result_t res
);
  import urms_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] WIDTH_MAX = '1;

  logic [CNT16_W-1:0]     trigger_count_r, trigger_count_nxt;
  logic                   echo_previous_r, echo_previous_nxt;
  logic                   echo_waiting_r, echo_waiting_nxt;
  logic [COUNT_WIDTH-1:0] echo_width_r, echo_width_nxt;
  logic [REM_W-1:0]       echo_rem_r, echo_rem_nxt;
  logic [DIST_W-1:0]      echo_quot_r, echo_quot_nxt;
  logic [DIST_W-1:0]      range_cm_r, range_cm_nxt;
  logic                   running_r, running_nxt;
  logic [CNT16_W-1:0]     hold_count_r, hold_count_nxt;
  logic [CNT16_W-1:0]     pwm_count_r, pwm_count_nxt;
  logic [DUTY_W-1:0]      duty_value_r, duty_value_nxt;

  logic                   fresh;
  logic [PCT_W-1:0]       speed;
  logic [DUTY_W-1:0]      duty_prod;
  logic [SCALE_W-1:0]     pwm_scaled;
  logic [CNT16_W:0]       trig_inc;
  logic                   trig;
  logic                   pwm;

  // Echo timing; the quotient by 58 is tracked alongside the width count.
  always_comb begin
    echo_width_nxt   = echo_width_r;
    echo_rem_nxt     = echo_rem_r;
    echo_quot_nxt    = echo_quot_r;
    echo_waiting_nxt = echo_waiting_r;
    range_cm_nxt     = range_cm_r;
    fresh            = 1'b0;
    if (echo_waiting_r) begin
      if (echo_width_r != WIDTH_MAX) begin
        echo_width_nxt = echo_width_r + 1'b1;
        if (echo_rem_r == REM_LAST) begin
          echo_rem_nxt = '0;
          if (echo_quot_r != DIST_MAX) begin
            echo_quot_nxt = echo_quot_r + 1'b1;
          end
        end else begin
          echo_rem_nxt = echo_rem_r + 1'b1;
        end
      end
      if (!echo_level) begin
        range_cm_nxt     = echo_quot_nxt;
        fresh            = 1'b1;
        echo_waiting_nxt = 1'b0;
      end
    end else if (echo_level && !echo_previous_r) begin
      echo_waiting_nxt = 1'b1;
      echo_width_nxt   = '0;
      echo_rem_nxt     = '0;
      echo_quot_nxt    = '0;
    end
    echo_previous_nxt = echo_level;
  end

  // Duty is kept as pwm_period * speed; the divide by 100 moves into the compare.
  assign speed     = (cfg.speed_percent > SPEED_MAX) ? SPEED_MAX : cfg.speed_percent;
  assign duty_prod = DUTY_W'(cfg.pwm_period) * DUTY_W'(speed);

  // Stop/start decision on the freshly updated range.
  always_comb begin
    running_nxt    = running_r;
    duty_value_nxt = duty_value_r;
    hold_count_nxt = hold_count_r;
    if (hold_count_r != '0) begin
      hold_count_nxt = hold_count_r - 1'b1;
    end else if (range_cm_nxt != '0 && range_cm_nxt < cfg.stop_below_cm) begin
      running_nxt    = 1'b0;
      duty_value_nxt = '0;
      hold_count_nxt = cfg.hold_ticks;
    end else if (range_cm_nxt >= cfg.start_from_cm && !running_r) begin
      running_nxt    = 1'b1;
      duty_value_nxt = duty_prod;
    end
  end

  // Trigger pulse from the count before it advances.
  assign trig     = trigger_count_r < CNT16_W'(cfg.trigger_width);
  assign trig_inc = {1'b0, trigger_count_r} + 1'b1;
  assign trigger_count_nxt = (trig_inc >= {1'b0, cfg.trigger_period}) ? '0
                                                                       : trig_inc[CNT16_W-1:0];

  // Reset/set PWM: count < product/100 exactly when 100*(count+1) <= product.
  assign pwm_scaled    = (SCALE_W'(pwm_count_r) + 1'b1) * PCT_SCALE;
  assign pwm           = running_nxt && (pwm_scaled <= SCALE_W'(duty_value_nxt));
  assign pwm_count_nxt = (pwm_count_r >= cfg.pwm_period) ? '0 : pwm_count_r + 1'b1;

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_count_r <= '0;
      echo_previous_r <= 1'b0;
      echo_waiting_r  <= 1'b0;
      echo_width_r    <= '0;
      echo_rem_r      <= '0;
      echo_quot_r     <= '0;
      range_cm_r      <= '0;
      running_r       <= 1'b0;
      hold_count_r    <= '0;
      pwm_count_r     <= '0;
      duty_value_r    <= '0;
    end else if (step) begin
      trigger_count_r <= trigger_count_nxt;
      echo_previous_r <= echo_previous_nxt;
      echo_waiting_r  <= echo_waiting_nxt;
      echo_width_r    <= echo_width_nxt;
      echo_rem_r      <= echo_rem_nxt;
      echo_quot_r     <= echo_quot_nxt;
      range_cm_r      <= range_cm_nxt;
      running_r       <= running_nxt;
      hold_count_r    <= hold_count_nxt;
      pwm_count_r     <= pwm_count_nxt;
      duty_value_r    <= duty_value_nxt;
    end
  end

  // Result of this tick.
  always_comb begin
    res.trigger_out    = trig;
    res.pwm_left       = pwm;
    res.pwm_right      = pwm;
    res.left_in1       = 1'b0;
    res.left_in2       = running_nxt;
    res.right_in1      = running_nxt;
    res.right_in2      = 1'b0;
    res.distance_cm    = range_cm_nxt;
    res.distance_new   = fresh;
    res.motors_running = running_nxt;
  end

endmodule

// ===== tb/ultrasonic_ranger_motor_stop_tb.sv =====
// Self-checking testbench for the ultrasonic ranger with motor stop and PWM drive.
module ultrasonic_ranger_motor_stop_tb;
  import urms_pkg::*;

  localparam int unsigned ECHO_TICKS_PER_CM = 58;
  localparam int unsigned FULL_SPEED = 100;
  localparam logic [CNT16_W-1:0] WIDTH_SAT = '1;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQUESTS = 110;
  localparam int MAX_GAP = 13;
  localparam int MAX_REPORTS = 50;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid;
  logic                  in_tready;
  // tdata: [0] echo_level, [7:1] zero
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // tdata: [0] trigger_out, [1] pwm_left, [2] pwm_right, [3] left_in1, [4] left_in2,
  //        [5] right_in1, [6] right_in2, [17:7] distance_cm, [18] distance_new,
  //        [19] motors_running, [23:20] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [ADDR_W-1:0]     cfg_paddr;
  logic [DATA_W-1:0]     cfg_pwdata;
  logic [DATA_W-1:0]     cfg_prdata;
  logic                  cfg_pready;

  // Traffic shaping: per-side no-gap stretches.
  bit src_fast;
  bit sink_fast;

  int mismatches;
  int results_seen;

  // Register shadow, updated on each register write, and ranger state, updated on every accepted request.
  cfg_t               cfg_model;
  logic [CNT16_W-1:0] trig_count = '0;
  logic               echo_last = 1'b0;
  logic               echo_armed = 1'b0;
  logic [CNT16_W-1:0] echo_ticks = '0;
  logic [DIST_W-1:0]  range_now = '0;
  logic               motors_on = 1'b0;
  logic [CNT16_W-1:0] hold_left = '0;
  logic [CNT16_W-1:0] pwm_count = '0;
  logic [CNT16_W-1:0] duty = '0;

  // Pin levels still owed by the block, oldest first.
  result_t pin_levels_due[$];

  ultrasonic_ranger_motor_stop u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advances the ranger by one tick and returns the pin levels it shows.
  function automatic result_t step_ranger(input logic echo);
    result_t     pins;
    logic        fresh;
    logic        trig;
    logic        pwm;
    int unsigned spd;
    fresh = 1'b0;

    // Echo timing: arm on a rising edge, latch the range on the falling edge.
    if (echo_armed) begin
      if (echo_ticks != WIDTH_SAT) echo_ticks++;
      if (!echo) begin
        range_now = DIST_W'(echo_ticks / ECHO_TICKS_PER_CM);
        fresh = 1'b1;
        echo_armed = 1'b0;
      end
    end else if (echo && !echo_last) begin
      echo_armed = 1'b1;
      echo_ticks = '0;
    end
    echo_last = echo;

    // Stop wins over start; a stop freezes decisions for the hold time.
    if (hold_left != 0) begin
      hold_left--;
    end else if (range_now != 0 && range_now < cfg_model.stop_below_cm) begin
      motors_on = 1'b0;
      duty = '0;
      hold_left = cfg_model.hold_ticks;
    end else if (range_now >= cfg_model.start_from_cm && !motors_on) begin
      spd = (cfg_model.speed_percent > FULL_SPEED) ? FULL_SPEED : cfg_model.speed_percent;
      motors_on = 1'b1;
      duty = CNT16_W'((32'(cfg_model.pwm_period) * spd) / FULL_SPEED);
    end

    // Trigger and PWM levels come from the counts before they advance.
    trig = (trig_count < cfg_model.trigger_width);
    if (32'(trig_count) + 32'd1 >= 32'(cfg_model.trigger_period)) trig_count = '0;
    else trig_count++;

    pwm = motors_on && (pwm_count < duty);
    if (pwm_count >= cfg_model.pwm_period) pwm_count = '0;
    else pwm_count++;

    pins.trigger_out    = trig;
    pins.pwm_left       = pwm;
    pins.pwm_right      = pwm;
    pins.left_in1       = 1'b0;
    pins.left_in2       = motors_on;
    pins.right_in1      = motors_on;
    pins.right_in2      = 1'b0;
    pins.distance_cm    = range_now;
    pins.distance_new   = fresh;
    pins.motors_running = motors_on;
    return pins;
  endfunction

  // Sets bits above the register width so that the write has to mask them.
  function automatic logic [DATA_W-1:0] add_junk(input logic [DATA_W-1:0] value,
                                                 input int width);
    return value | (DATA_W'($urandom) << width);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                results_seen, name, got, want));
  endtask

  // Sends a tick request after a random gap (none if src_fast); returns at the negedge after acceptance.
  task automatic send_tick(input logic echo);
    int gap;
    gap = src_fast ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = IN_DATA_W'(echo);
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Stops sending and waits until every owed result has come back.
  task automatic settle();
    in_tvalid = 1'b0;
    while (pin_levels_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Two-phase register write; the block takes it at the access-phase rising edge.
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = ADDR_W'({idx, 2'b00});
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    case (idx)
      REG_TRIG_PERIOD: cfg_model.trigger_period = value[CNT16_W-1:0];
      REG_TRIG_WIDTH:  cfg_model.trigger_width  = value[TWID_W-1:0];
      REG_PWM_PERIOD:  cfg_model.pwm_period     = value[CNT16_W-1:0];
      REG_SPEED:       cfg_model.speed_percent  = value[PCT_W-1:0];
      REG_STOP_BELOW:  cfg_model.stop_below_cm  = value[DIST_W-1:0];
      REG_START_FROM:  cfg_model.start_from_cm  = value[DIST_W-1:0];
      REG_HOLD_TICKS:  cfg_model.hold_ticks     = value[CNT16_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  // Default registers: trigger pulse at the start, a one-tick echo gives a zero range.
  task automatic test_reset_defaults();
    repeat (3) send_tick(1'b0);
    send_tick(1'b1);
    repeat (8) send_tick(1'b0);
  endtask

  // Zero trigger period and width, then the widest pulse in a one-tick period.
  task automatic test_trigger_limits();
    settle();
    write_reg(REG_TRIG_PERIOD, '0);
    write_reg(REG_TRIG_WIDTH, '0);
    repeat (3) send_tick(1'b0);
    settle();
    write_reg(REG_TRIG_WIDTH, DATA_W'(8'hFF));
    write_reg(REG_TRIG_PERIOD, DATA_W'(1));
    repeat (3) send_tick(1'b0);
  endtask

  // A zero start threshold starts the motors at once; speed above full is clamped.
  task automatic test_speed_limits();
    settle();
    write_reg(REG_STOP_BELOW, '0);
    write_reg(REG_START_FROM, '0);
    write_reg(REG_SPEED, DATA_W'(7'h7F));
    write_reg(REG_PWM_PERIOD, DATA_W'(3));
    repeat (6) send_tick(1'b0);
  endtask

  // Counts left above a lowered top wrap to zero; the kept duty then exceeds the top.
  task automatic test_counter_wrap();
    settle();
    write_reg(REG_TRIG_PERIOD, DATA_W'(16'hFFFF));
    write_reg(REG_TRIG_WIDTH, DATA_W'(3));
    write_reg(REG_PWM_PERIOD, DATA_W'(16'hFFFF));
    repeat (6) send_tick(1'b0);
    settle();
    write_reg(REG_TRIG_PERIOD, DATA_W'(2));
    write_reg(REG_PWM_PERIOD, DATA_W'(1));
    repeat (4) send_tick(1'b0);
  endtask

  // Phases of echo pulses under new register settings; first all lows, last all highs.
  task automatic test_random_ranging();
    logic [DATA_W-1:0] t_per, t_wid, p_per, spd, stop_cm, start_cm, hold;
    int sent, low, high, n;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      if (phase == 0) begin
        t_per = '0; t_wid = '0; p_per = '0; spd = '0;
        stop_cm = '0; start_cm = '0; hold = '0;
      end else if (phase == RANDOM_PHASES - 1) begin
        t_per = DATA_W'(16'hFFFF); t_wid = DATA_W'(8'hFF); p_per = DATA_W'(16'hFFFF);
        spd = DATA_W'(7'h7F); stop_cm = DATA_W'(11'h7FF); start_cm = DATA_W'(11'h7FF);
        hold = DATA_W'(16'hFFFF);
      end else begin
        t_per = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40);
        t_wid = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
        p_per = $urandom_range(0, 15);
        spd = $urandom_range(0, 127);
        stop_cm = $urandom_range(0, 4);
        start_cm = $urandom_range(0, 4);
        hold = $urandom_range(0, 60);
        t_per = add_junk(t_per, CNT16_W);
        t_wid = add_junk(t_wid, TWID_W);
        p_per = add_junk(p_per, CNT16_W);
        spd = add_junk(spd, PCT_W);
        stop_cm = add_junk(stop_cm, DIST_W);
        start_cm = add_junk(start_cm, DIST_W);
        hold = add_junk(hold, CNT16_W);
      end
      write_reg(REG_TRIG_PERIOD, t_per);
      write_reg(REG_TRIG_WIDTH, t_wid);
      write_reg(REG_PWM_PERIOD, p_per);
      write_reg(REG_SPEED, spd);
      write_reg(REG_STOP_BELOW, stop_cm);
      write_reg(REG_START_FROM, start_cm);
      write_reg(REG_HOLD_TICKS, hold);

      // Mostly clean pulses of one to three centimeters, some short ones and some noise.
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        src_fast = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 4) != 0) begin
          low = $urandom_range(1, 12);
          high = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 57) : $urandom_range(58, 200);
          repeat (low) send_tick(1'b0);
          repeat (high) send_tick(1'b1);
          sent += low + high;
        end else begin
          n = $urandom_range(1, 10);
          repeat (n) send_tick(1'($urandom_range(0, 1)));
          sent += n;
        end
      end
    end
    src_fast = 1'b0;
  endtask

  // Predicts each accepted request and checks each accepted result against the oldest one.
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) pin_levels_due.push_back(step_ranger(in_tdata[0]));
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (pin_levels_due.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with none expected", results_seen));
        end else begin
          want = pin_levels_due.pop_front();
          compare_field("trigger_out", out_tdata[0], want.trigger_out);
          compare_field("pwm_left", out_tdata[1], want.pwm_left);
          compare_field("pwm_right", out_tdata[2], want.pwm_right);
          compare_field("left_in1", out_tdata[3], want.left_in1);
          compare_field("left_in2", out_tdata[4], want.left_in2);
          compare_field("right_in1", out_tdata[5], want.right_in1);
          compare_field("right_in2", out_tdata[6], want.right_in2);
          compare_field("distance_cm", out_tdata[17:7], want.distance_cm);
          compare_field("distance_new", out_tdata[18], want.distance_new);
          compare_field("motors_running", out_tdata[19], want.motors_running);
        end
      end
    end
  end

  // Result side: a random stall before each result, with occasional no-stall stretches.
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 63) == 0) sink_fast = !sink_fast;
      stall = sink_fast ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    #100_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : run
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cfg_model.trigger_period = TRIG_PERIOD_RST;
    cfg_model.trigger_width = TRIG_WIDTH_RST;
    cfg_model.pwm_period = PWM_PERIOD_RST;
    cfg_model.speed_percent = SPEED_RST;
    cfg_model.stop_below_cm = STOP_BELOW_RST;
    cfg_model.start_from_cm = START_FROM_RST;
    cfg_model.hold_ticks = HOLD_TICKS_RST;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_trigger_limits();
    test_speed_limits();
    test_counter_wrap();
    test_random_ranging();

    // Drain, then wait for anything stray to show up.
    settle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pin_levels_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== ultrasonic_ranger_motor_stop.f =====
design/urms_pkg.sv
design/urms_regs.sv
design/urms_core.sv
design/ultrasonic_ranger_motor_stop.sv
tb/ultrasonic_ranger_motor_stop_tb.sv
